// File: hw/rtl/rha_pkg.sv
package rha_pkg;

    localparam int MaxHandles = 32;
    localparam int IdxW       = (MaxHandles > 1) ? $clog2(MaxHandles) : 1;
    localparam int CntW       = $clog2(MaxHandles + 1);
    localparam int HidW       = 6;
    localparam int OffW       = 25;
    localparam int AlignW     = 13;
    localparam int GenW       = 32;
    localparam int StatW      = 3;
    localparam int TypeW      = 2;

    localparam logic [OffW-1:0] CapReset = OffW'(65536);

    typedef enum logic [TypeW-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_RESOLVE = 2'd2,
        REQ_COMPACT = 2'd3
    } t_req;

    typedef enum logic [StatW-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_REQ  = 3'd1,
        ST_NO_HDL   = 3'd2,
        ST_NO_SPACE = 3'd3,
        ST_STALE    = 3'd4,
        ST_CP_FAIL  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AL_READ,
        S_AL_COMMIT,
        S_HDL_CHK,
        S_CP_START,
        S_CP_SCAN,
        S_CP_PICK,
        S_CP_LOAD,
        S_CP_END,
        S_AL_FIT2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              we_entry;
        logic              we_off;
        logic              we_nf;
        logic [IdxW-1:0]   addr;
        logic [OffW-1:0]   off;
        logic [OffW-1:0]   size;
        logic [AlignW-1:0] align;
        logic [GenW-1:0]   gen;
        logic [HidW-1:0]   nf;
    } t_tbl_wr;

    typedef struct packed {
        logic [OffW-1:0]   off;
        logic [OffW-1:0]   size;
        logic [AlignW-1:0] align;
        logic [GenW-1:0]   gen;
        logic [HidW-1:0]   nf;
    } t_tbl_rd;

endpackage

// File: hw/rtl/rha_table.sv
module rha_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [rha_pkg::IdxW-1:0] i_rd_addr,
    input  rha_pkg::t_tbl_wr         i_wr,
    output rha_pkg::t_tbl_rd         o_rd
);

    logic [rha_pkg::OffW-1:0]   r_mem_off   [rha_pkg::MaxHandles];
    logic [rha_pkg::OffW-1:0]   r_mem_size  [rha_pkg::MaxHandles];
    logic [rha_pkg::AlignW-1:0] r_mem_align [rha_pkg::MaxHandles];
    logic [rha_pkg::GenW-1:0]   r_mem_gen   [rha_pkg::MaxHandles];
    logic [rha_pkg::HidW-1:0]   r_mem_nf    [rha_pkg::MaxHandles];
    logic [rha_pkg::MaxHandles-1:0] r_nf_wr;

    logic [rha_pkg::OffW-1:0]   r_rd_off;
    logic [rha_pkg::OffW-1:0]   r_rd_size;
    logic [rha_pkg::AlignW-1:0] r_rd_align;
    logic [rha_pkg::GenW-1:0]   r_rd_gen;
    logic [rha_pkg::HidW-1:0]   r_rd_nf;
    logic [rha_pkg::IdxW-1:0]   r_rd_addr;
    logic                       r_rd_nf_wr;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_entry) begin
            r_mem_size[i_wr.addr]  <= i_wr.size;
            r_mem_align[i_wr.addr] <= i_wr.align;
            r_mem_gen[i_wr.addr]   <= i_wr.gen;
        end
        if (i_wr.we_entry || i_wr.we_off) begin
            r_mem_off[i_wr.addr] <= i_wr.off;
        end
        if (i_wr.we_nf) begin
            r_mem_nf[i_wr.addr] <= i_wr.nf;
        end
        r_rd_off   <= r_mem_off[i_rd_addr];
        r_rd_size  <= r_mem_size[i_rd_addr];
        r_rd_align <= r_mem_align[i_rd_addr];
        r_rd_gen   <= r_mem_gen[i_rd_addr];
        r_rd_nf    <= r_mem_nf[i_rd_addr];
        r_rd_addr  <= i_rd_addr;
    end

    // Until an entry's link is first written it reads as the next index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf_wr    <= '0;
            r_rd_nf_wr <= 1'b0;
        end else begin
            if (i_wr.we_nf) begin
                r_nf_wr[i_wr.addr] <= 1'b1;
            end
            r_rd_nf_wr <= r_nf_wr[i_rd_addr];
        end
    end

    always_comb begin
        o_rd.off   = r_rd_off;
        o_rd.size  = r_rd_size;
        o_rd.align = r_rd_align;
        o_rd.gen   = r_rd_gen;
        o_rd.nf    = r_rd_nf_wr ? r_rd_nf
                                : rha_pkg::HidW'({1'b0, r_rd_addr} + (rha_pkg::IdxW+1)'(1));
    end

endmodule

// File: hw/rtl/rha_place.sv
module rha_place (
    input  logic [rha_pkg::OffW-1:0]   i_cursor,
    input  logic [rha_pkg::AlignW-1:0] i_align,
    input  logic [rha_pkg::OffW-1:0]   i_size,
    input  logic [rha_pkg::OffW-1:0]   i_cap,
    output logic [rha_pkg::OffW-1:0]   o_off,
    output logic                       o_fits
);

    logic [rha_pkg::OffW:0] mask;
    logic [rha_pkg::OffW:0] bumped;
    logic [rha_pkg::OffW:0] aligned;
    logic [rha_pkg::OffW:0] cap_ext;

    // Alignment is a nonzero power of two here, so rounding up is add and mask.
    always_comb begin
        mask    = (rha_pkg::OffW+1)'(i_align) - (rha_pkg::OffW+1)'(1);
        bumped  = {1'b0, i_cursor} + mask;
        aligned = bumped & ~mask;
        cap_ext = {1'b0, i_cap};
        o_off   = aligned[rha_pkg::OffW-1:0];
        o_fits  = (i_cursor <= i_cap) && (aligned <= cap_ext)
                  && ({1'b0, i_size} <= (cap_ext - aligned));
    end

endmodule

// File: hw/rtl/relocatable_handle_allocator_unit.sv
// Channel   | Handshake                  | Payload
// request   | i_in_valid / o_in_stall    | i_req_type .. i_handle_generation
// result    | o_out_valid / i_out_stall  | o_is_move .. o_last
// config    | i_cfg_we                   | i_cfg_data (arena capacity)
//
// Outside compaction, alloc, free and resolve each do one table read, plus
// output wait. Compact walks the table with a single read port, rescanning
// the whole table for each entry that it places.
// Reset is synchronous; no clearing pass is needed, the table is usable at once.
// Output stalls hold the sequencer only where it has a beat to deliver.
module relocatable_handle_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [rha_pkg::TypeW-1:0]  i_req_type,
    input  logic [rha_pkg::OffW-1:0]   i_req_size,
    input  logic [rha_pkg::AlignW-1:0] i_req_alignment,
    input  logic [rha_pkg::HidW-1:0]   i_handle_index,
    input  logic [rha_pkg::GenW-1:0]   i_handle_generation,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_move,
    output logic [rha_pkg::StatW-1:0]  o_status,
    output logic [rha_pkg::HidW-1:0]   o_out_index,
    output logic [rha_pkg::GenW-1:0]   o_out_generation,
    output logic [rha_pkg::OffW-1:0]   o_out_offset,
    output logic [rha_pkg::OffW-1:0]   o_source_offset,
    output logic [rha_pkg::OffW-1:0]   o_out_size,
    output logic [rha_pkg::OffW-1:0]   o_reclaimed_bytes,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [rha_pkg::OffW-1:0]   i_cfg_data
);

    rha_pkg::t_state r_state, n_state;

    logic [rha_pkg::OffW-1:0]   r_capacity;
    logic [rha_pkg::TypeW-1:0]  r_req_type, n_req_type;
    logic [rha_pkg::OffW-1:0]   r_req_size, n_req_size;
    logic [rha_pkg::AlignW-1:0] r_req_align, n_req_align;
    logic [rha_pkg::HidW-1:0]   r_req_idx, n_req_idx;
    logic [rha_pkg::GenW-1:0]   r_req_gen, n_req_gen;

    logic [rha_pkg::MaxHandles-1:0] r_live, n_live;
    logic [rha_pkg::HidW-1:0]   r_free_head, n_free_head;
    logic [rha_pkg::OffW-1:0]   r_bump, n_bump;
    logic [rha_pkg::OffW-1:0]   r_live_bytes, n_live_bytes;
    logic [rha_pkg::CntW-1:0]   r_live_count, n_live_count;
    logic [rha_pkg::GenW-1:0]   r_next_gen, n_next_gen;

    logic                       r_cp_alloc, n_cp_alloc;
    logic [rha_pkg::MaxHandles-1:0] r_done, n_done;
    logic [rha_pkg::OffW-1:0]   r_write, n_write;
    logic [rha_pkg::CntW-1:0]   r_scan, n_scan;
    logic                       r_rd_pend, n_rd_pend;
    logic [rha_pkg::IdxW-1:0]   r_rd_idx, n_rd_idx;
    logic                       r_found, n_found;
    logic [rha_pkg::IdxW-1:0]   r_best, n_best;
    logic [rha_pkg::OffW-1:0]   r_best_off, n_best_off;
    logic [rha_pkg::OffW-1:0]   r_off, n_off;

    logic [rha_pkg::StatW-1:0]  r_resp_status, n_resp_status;
    logic [rha_pkg::HidW-1:0]   r_resp_idx, n_resp_idx;
    logic [rha_pkg::GenW-1:0]   r_resp_gen, n_resp_gen;
    logic [rha_pkg::OffW-1:0]   r_resp_off, n_resp_off;
    logic [rha_pkg::OffW-1:0]   r_resp_size, n_resp_size;
    logic [rha_pkg::OffW-1:0]   r_resp_recl, n_resp_recl;

    logic                       r_out_valid;
    logic                       r_o_move, n_o_move;
    logic [rha_pkg::StatW-1:0]  r_o_status, n_o_status;
    logic [rha_pkg::HidW-1:0]   r_o_idx, n_o_idx;
    logic [rha_pkg::GenW-1:0]   r_o_gen, n_o_gen;
    logic [rha_pkg::OffW-1:0]   r_o_off, n_o_off;
    logic [rha_pkg::OffW-1:0]   r_o_src, n_o_src;
    logic [rha_pkg::OffW-1:0]   r_o_size, n_o_size;
    logic [rha_pkg::OffW-1:0]   r_o_recl, n_o_recl;
    logic                       r_o_last, n_o_last;
    logic                       emit;

    rha_pkg::t_tbl_wr           tbl_wr;
    rha_pkg::t_tbl_rd           tbl_rd;
    logic [rha_pkg::IdxW-1:0]   rd_addr;

    logic [rha_pkg::OffW-1:0]   pl_cursor;
    logic [rha_pkg::AlignW-1:0] pl_align;
    logic [rha_pkg::OffW-1:0]   pl_size;
    logic [rha_pkg::OffW-1:0]   pl_off;
    logic                       pl_fits;

    logic                       out_free;
    logic                       req_bad;
    logic                       no_handle;
    logic                       room;
    logic                       idx_bad;
    logic                       hdl_ok;
    logic                       moved;
    logic [rha_pkg::IdxW-1:0]   req_idx5;
    logic [rha_pkg::IdxW-1:0]   head5;
    logic [rha_pkg::GenW-1:0]   grant_gen;

    rha_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (tbl_wr),
        .o_rd      (tbl_rd)
    );

    rha_place u_place (
        .i_cursor (pl_cursor),
        .i_align  (pl_align),
        .i_size   (pl_size),
        .i_cap    (r_capacity),
        .o_off    (pl_off),
        .o_fits   (pl_fits)
    );

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        req_idx5  = r_req_idx[rha_pkg::IdxW-1:0];
        head5     = r_free_head[rha_pkg::IdxW-1:0];
        req_bad   = (r_req_size == '0)
                    || ((r_req_align & (r_req_align - rha_pkg::AlignW'(1))) != '0);
        no_handle = (r_live_count >= rha_pkg::CntW'(rha_pkg::MaxHandles))
                    || (r_free_head >= rha_pkg::HidW'(rha_pkg::MaxHandles));
        room      = (r_live_bytes <= r_capacity)
                    && (r_req_size <= (r_capacity - r_live_bytes));
        idx_bad   = (r_req_gen == '0) || (r_req_idx >= rha_pkg::HidW'(rha_pkg::MaxHandles));
        hdl_ok    = r_live[req_idx5] && (tbl_rd.gen == r_req_gen);
        moved     = (pl_off != tbl_rd.off);
        // Generation zero is never handed out.
        grant_gen = (r_next_gen == '0) ? rha_pkg::GenW'(1) : r_next_gen;

        if (r_state == rha_pkg::S_CP_LOAD) begin
            pl_cursor = r_write;
            pl_align  = tbl_rd.align;
            pl_size   = tbl_rd.size;
        end else begin
            pl_cursor = r_bump;
            pl_align  = r_req_align;
            pl_size   = r_req_size;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rha_pkg::S_DECODE;
                end
            end
            rha_pkg::S_DECODE: begin
                case (r_req_type)
                    rha_pkg::REQ_ALLOC: begin
                        if (req_bad || no_handle) begin
                            n_state = rha_pkg::S_RESP;
                        end else if (pl_fits) begin
                            n_state = rha_pkg::S_AL_READ;
                        end else if (room) begin
                            n_state = rha_pkg::S_CP_START;
                        end else begin
                            n_state = rha_pkg::S_RESP;
                        end
                    end
                    rha_pkg::REQ_FREE, rha_pkg::REQ_RESOLVE: begin
                        n_state = idx_bad ? rha_pkg::S_RESP : rha_pkg::S_HDL_CHK;
                    end
                    default: begin
                        n_state = rha_pkg::S_CP_START;
                    end
                endcase
            end
            rha_pkg::S_AL_READ:   n_state = rha_pkg::S_AL_COMMIT;
            rha_pkg::S_AL_COMMIT: n_state = rha_pkg::S_RESP;
            rha_pkg::S_HDL_CHK:   n_state = rha_pkg::S_RESP;
            rha_pkg::S_CP_START:  n_state = rha_pkg::S_CP_SCAN;
            rha_pkg::S_CP_SCAN: begin
                if (r_scan == rha_pkg::CntW'(rha_pkg::MaxHandles)) begin
                    n_state = rha_pkg::S_CP_PICK;
                end
            end
            rha_pkg::S_CP_PICK: begin
                n_state = r_found ? rha_pkg::S_CP_LOAD : rha_pkg::S_CP_END;
            end
            rha_pkg::S_CP_LOAD: begin
                if (!pl_fits) begin
                    n_state = rha_pkg::S_RESP;
                end else if (!moved || out_free) begin
                    n_state = rha_pkg::S_CP_SCAN;
                end
            end
            rha_pkg::S_CP_END: begin
                n_state = r_cp_alloc ? rha_pkg::S_AL_FIT2 : rha_pkg::S_RESP;
            end
            rha_pkg::S_AL_FIT2: begin
                n_state = pl_fits ? rha_pkg::S_AL_READ : rha_pkg::S_RESP;
            end
            rha_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = rha_pkg::S_IDLE;
                end
            end
            default: n_state = rha_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_req_type    = r_req_type;
        n_req_size    = r_req_size;
        n_req_align   = r_req_align;
        n_req_idx     = r_req_idx;
        n_req_gen     = r_req_gen;
        n_live        = r_live;
        n_free_head   = r_free_head;
        n_bump        = r_bump;
        n_live_bytes  = r_live_bytes;
        n_live_count  = r_live_count;
        n_next_gen    = r_next_gen;
        n_cp_alloc    = r_cp_alloc;
        n_done        = r_done;
        n_write       = r_write;
        n_scan        = r_scan;
        n_rd_pend     = r_rd_pend;
        n_rd_idx      = r_rd_idx;
        n_found       = r_found;
        n_best        = r_best;
        n_best_off    = r_best_off;
        n_off         = r_off;
        n_resp_status = r_resp_status;
        n_resp_idx    = r_resp_idx;
        n_resp_gen    = r_resp_gen;
        n_resp_off    = r_resp_off;
        n_resp_size   = r_resp_size;
        n_resp_recl   = r_resp_recl;

        emit       = 1'b0;
        n_o_move   = 1'b0;
        n_o_status = r_resp_status;
        n_o_idx    = r_resp_idx;
        n_o_gen    = r_resp_gen;
        n_o_off    = r_resp_off;
        n_o_src    = '0;
        n_o_size   = r_resp_size;
        n_o_recl   = r_resp_recl;
        n_o_last   = 1'b1;

        rd_addr         = req_idx5;
        tbl_wr          = '0;
        tbl_wr.addr     = req_idx5;

        case (r_state)
            rha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req_type  = i_req_type;
                    n_req_size  = i_req_size;
                    n_req_align = (i_req_alignment == '0) ? rha_pkg::AlignW'(1)
                                                          : i_req_alignment;
                    n_req_idx   = i_handle_index;
                    n_req_gen   = i_handle_generation;
                end
            end
            rha_pkg::S_DECODE: begin
                n_resp_status = rha_pkg::ST_OK;
                n_resp_idx    = '0;
                n_resp_gen    = '0;
                n_resp_off    = '0;
                n_resp_size   = '0;
                n_resp_recl   = '0;
                case (r_req_type)
                    rha_pkg::REQ_ALLOC: begin
                        n_cp_alloc = 1'b1;
                        n_off      = pl_off;
                        if (req_bad) begin
                            n_resp_status = rha_pkg::ST_BAD_REQ;
                        end else if (no_handle) begin
                            n_resp_status = rha_pkg::ST_NO_HDL;
                        end else if (!pl_fits && !room) begin
                            n_resp_status = rha_pkg::ST_NO_SPACE;
                        end
                    end
                    rha_pkg::REQ_FREE, rha_pkg::REQ_RESOLVE: begin
                        if (idx_bad) begin
                            n_resp_status = rha_pkg::ST_STALE;
                        end
                    end
                    default: begin
                        n_cp_alloc = 1'b0;
                    end
                endcase
            end
            rha_pkg::S_AL_READ: begin
                rd_addr = head5;
            end
            rha_pkg::S_AL_COMMIT: begin
                rd_addr         = head5;
                tbl_wr.we_entry = 1'b1;
                tbl_wr.addr     = head5;
                tbl_wr.off      = r_off;
                tbl_wr.size     = r_req_size;
                tbl_wr.align    = r_req_align;
                tbl_wr.gen      = grant_gen;
                n_live[head5]   = 1'b1;
                n_free_head     = tbl_rd.nf;
                n_bump          = r_off + r_req_size;
                n_live_bytes    = r_live_bytes + r_req_size;
                n_live_count    = r_live_count + rha_pkg::CntW'(1);
                n_next_gen      = grant_gen + rha_pkg::GenW'(1);
                n_resp_status   = rha_pkg::ST_OK;
                n_resp_idx      = r_free_head;
                n_resp_gen      = grant_gen;
                n_resp_off      = r_off;
                n_resp_size     = '0;
                n_resp_recl     = '0;
            end
            rha_pkg::S_HDL_CHK: begin
                if (!hdl_ok) begin
                    n_resp_status = rha_pkg::ST_STALE;
                end else if (r_req_type == rha_pkg::REQ_FREE) begin
                    n_live[req_idx5] = 1'b0;
                    n_live_bytes     = (r_live_bytes >= tbl_rd.size)
                                       ? r_live_bytes - tbl_rd.size : '0;
                    if (r_live_count != '0) begin
                        n_live_count = r_live_count - rha_pkg::CntW'(1);
                    end
                    tbl_wr.we_nf = 1'b1;
                    tbl_wr.nf    = r_free_head;
                    n_free_head  = r_req_idx;
                end else begin
                    n_resp_off  = tbl_rd.off;
                    n_resp_size = tbl_rd.size;
                end
            end
            rha_pkg::S_CP_START: begin
                n_done    = '0;
                n_write   = '0;
                n_scan    = '0;
                n_rd_pend = 1'b0;
                n_found   = 1'b0;
            end
            rha_pkg::S_CP_SCAN: begin
                // One table read a cycle; the data of the previous address is compared.
                rd_addr = r_scan[rha_pkg::IdxW-1:0];
                if (r_scan != rha_pkg::CntW'(rha_pkg::MaxHandles)) begin
                    n_scan    = r_scan + rha_pkg::CntW'(1);
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_scan[rha_pkg::IdxW-1:0];
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend && r_live[r_rd_idx] && !r_done[r_rd_idx]
                    && (!r_found || (tbl_rd.off < r_best_off))) begin
                    n_found    = 1'b1;
                    n_best     = r_rd_idx;
                    n_best_off = tbl_rd.off;
                end
            end
            rha_pkg::S_CP_PICK: begin
                rd_addr = r_best;
            end
            rha_pkg::S_CP_LOAD: begin
                rd_addr = r_best;
                if (!pl_fits) begin
                    n_resp_status = r_cp_alloc ? rha_pkg::ST_NO_SPACE : rha_pkg::ST_CP_FAIL;
                    n_resp_recl   = '0;
                end else if (!moved || out_free) begin
                    if (moved) begin
                        emit          = 1'b1;
                        n_o_move      = 1'b1;
                        n_o_status    = rha_pkg::ST_OK;
                        n_o_idx       = '0;
                        n_o_gen       = '0;
                        n_o_off       = pl_off;
                        n_o_src       = tbl_rd.off;
                        n_o_size      = tbl_rd.size;
                        n_o_recl      = '0;
                        n_o_last      = 1'b0;
                        tbl_wr.we_off = 1'b1;
                        tbl_wr.addr   = r_best;
                        tbl_wr.off    = pl_off;
                    end
                    n_done[r_best] = 1'b1;
                    n_write        = pl_off + tbl_rd.size;
                    n_scan         = '0;
                    n_rd_pend      = 1'b0;
                    n_found        = 1'b0;
                end
            end
            rha_pkg::S_CP_END: begin
                n_resp_status = rha_pkg::ST_OK;
                n_resp_recl   = (r_bump > r_write) ? r_bump - r_write : '0;
                n_bump        = r_write;
            end
            rha_pkg::S_AL_FIT2: begin
                n_off = pl_off;
                if (!pl_fits) begin
                    n_resp_status = rha_pkg::ST_NO_SPACE;
                    n_resp_recl   = '0;
                end
            end
            rha_pkg::S_RESP: begin
                emit = out_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rha_pkg::S_IDLE;
            r_capacity   <= rha_pkg::CapReset;
            r_live       <= '0;
            r_free_head  <= '0;
            r_bump       <= '0;
            r_live_bytes <= '0;
            r_live_count <= '0;
            r_next_gen   <= rha_pkg::GenW'(1);
            r_cp_alloc   <= 1'b0;
            r_done       <= '0;
            r_scan       <= '0;
            r_rd_pend    <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_live       <= n_live;
            r_free_head  <= n_free_head;
            r_bump       <= n_bump;
            r_live_bytes <= n_live_bytes;
            r_live_count <= n_live_count;
            r_next_gen   <= n_next_gen;
            r_cp_alloc   <= n_cp_alloc;
            r_done       <= n_done;
            r_scan       <= n_scan;
            r_rd_pend    <= n_rd_pend;
            r_found      <= n_found;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type    <= n_req_type;
        r_req_size    <= n_req_size;
        r_req_align   <= n_req_align;
        r_req_idx     <= n_req_idx;
        r_req_gen     <= n_req_gen;
        r_write       <= n_write;
        r_rd_idx      <= n_rd_idx;
        r_best        <= n_best;
        r_best_off    <= n_best_off;
        r_off         <= n_off;
        r_resp_status <= n_resp_status;
        r_resp_idx    <= n_resp_idx;
        r_resp_gen    <= n_resp_gen;
        r_resp_off    <= n_resp_off;
        r_resp_size   <= n_resp_size;
        r_resp_recl   <= n_resp_recl;
        if (emit) begin
            r_o_move   <= n_o_move;
            r_o_status <= n_o_status;
            r_o_idx    <= n_o_idx;
            r_o_gen    <= n_o_gen;
            r_o_off    <= n_o_off;
            r_o_src    <= n_o_src;
            r_o_size   <= n_o_size;
            r_o_recl   <= n_o_recl;
            r_o_last   <= n_o_last;
        end
    end

    assign o_in_stall        = (r_state != rha_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_is_move         = r_o_move;
    assign o_status          = r_o_status;
    assign o_out_index       = r_o_idx;
    assign o_out_generation  = r_o_gen;
    assign o_out_offset      = r_o_off;
    assign o_source_offset   = r_o_src;
    assign o_out_size        = r_o_size;
    assign o_reclaimed_bytes = r_o_recl;
    assign o_last            = r_o_last;

`ifndef SYNTHESIS
    a_count_matches_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == int'(r_live_count))
        else $error("live count out of step with live bits");

    a_head_not_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head < rha_pkg::HidW'(rha_pkg::MaxHandles))
        |-> !r_live[r_free_head[rha_pkg::IdxW-1:0]])
        else $error("free list head points at a live entry");

    a_done_subset_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rha_pkg::S_CP_SCAN) |-> ((r_done & ~r_live) == '0))
        else $error("compaction marked a dead entry as placed");

    a_move_only_in_compaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_o_move) |-> (r_state == rha_pkg::S_CP_LOAD))
        else $error("move beat issued outside compaction");
`endif

endmodule
